FILE: rtl/core/lmfls_pkg.sv
// Shared constants, types and helper functions of the LED matrix frame loader and scanner.
package lmfls_pkg;

    localparam int ROWS       = 8;
    localparam int HEADER_LEN = 7;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int WROW_W     = $clog2(ROWS + 1);
    localparam int HDR_W      = $clog2(HEADER_LEN + 1);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    localparam logic CFG_HEADER_VALUE = 1'b0;
    localparam logic CFG_SCAN_TICKS   = 1'b1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0] RESET_HEADER_VALUE = 8'h00;
    localparam logic [7:0] RESET_SCAN_TICKS   = 8'd6;

    typedef logic [7:0] t_row_arr [ROWS];

    typedef struct packed {
        logic       done;
        logic [7:0] row_data;
    } t_parse_res;

    localparam logic [7:0] START_PATTERN [16] = '{
        8'h00, 8'h00, 8'h40, 8'h40, 8'h7E, 8'h40, 8'h40, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    function automatic logic [7:0] start_row(input int idx);
        return START_PATTERN[idx % 16];
    endfunction

    function automatic logic [7:0] row_select(input logic [ROW_W-1:0] idx);
        logic [7:0] sel;
        sel = 8'hFF;
        if (int'(idx) < 8) begin
            sel = ~(8'h80 >> idx);
        end
        return sel;
    endfunction

endpackage

FILE: rtl/core/lmfls_parser.sv
// Byte parser with header hunt, length capture and the frame buffer rows.
module lmfls_parser
    import lmfls_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_header_value,
    input  logic [ROW_W-1:0] i_rd_row,
    output t_parse_res       o_res
);

    logic [1:0]        r_phase,   n_phase;
    logic [HDR_W-1:0]  r_matched, n_matched;
    logic [7:0]        r_left,    n_left;
    logic [WROW_W-1:0] r_wrow,    n_wrow;
    t_row_arr          r_frame;
    logic              w_we;
    logic              w_done;
    logic [HDR_W:0]    w_match_inc;

    always_comb begin
        n_phase     = r_phase;
        n_matched   = r_matched;
        n_left      = r_left;
        n_wrow      = r_wrow;
        w_we        = 1'b0;
        w_done      = 1'b0;
        w_match_inc = {1'b0, r_matched} + 1'b1;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_header_value) begin
                    if (int'(w_match_inc) >= HEADER_LEN) begin
                        n_matched = '0;
                        n_phase   = PH_LEN;
                    end else begin
                        n_matched = w_match_inc[HDR_W-1:0];
                    end
                end else begin
                    n_matched = '0;
                end
            end
            PH_LEN: begin
                n_left = i_byte;
                n_wrow = '0;
                if (i_byte == 8'h00) begin
                    n_phase = PH_HUNT;
                    w_done  = 1'b1;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (int'(r_wrow) < ROWS) begin
                    w_we   = 1'b1;
                    n_wrow = r_wrow + 1'b1;
                end
                if (r_left != 8'h00) begin
                    n_left = r_left - 8'h01;
                end
                if (n_left == 8'h00) begin
                    n_phase   = PH_HUNT;
                    n_matched = '0;
                    w_done    = 1'b1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_comb begin
        o_res.done = w_done;
        if (i_step && w_we && (r_wrow[ROW_W-1:0] == i_rd_row)) begin
            o_res.row_data = i_byte;
        end else begin
            o_res.row_data = r_frame[i_rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_matched <= '0;
            r_left    <= '0;
            r_wrow    <= '0;
            for (int i = 0; i < ROWS; i++) begin
                r_frame[i] <= start_row(i);
            end
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_matched <= n_matched;
            r_left    <= n_left;
            r_wrow    <= n_wrow;
            if (w_we) begin
                r_frame[r_wrow[ROW_W-1:0]] <= i_byte;
            end
        end
    end

endmodule

FILE: rtl/core/lmfls_scanner.sv
// Row scan timer that counts ticks and advances the lit row.
module lmfls_scanner
    import lmfls_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tick,
    input  logic [7:0]       i_scan_ticks,
    output logic [ROW_W-1:0] o_row,
    output logic [ROW_W-1:0] o_next_row,
    output logic             o_advance
);

    logic [ROW_W-1:0] r_row;
    logic [7:0]       r_count;
    logic [8:0]       w_count_inc;
    logic [7:0]       w_limit;

    assign w_limit     = (i_scan_ticks == 8'h00) ? 8'h01 : i_scan_ticks;
    assign w_count_inc = {1'b0, r_count} + 9'd1;
    assign o_advance   = (w_count_inc >= {1'b0, w_limit});
    assign o_row       = r_row;
    assign o_next_row  = (int'(r_row) == ROWS - 1) ? '0 : r_row + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_count <= '0;
        end else if (i_tick) begin
            if (o_advance) begin
                r_count <= '0;
                r_row   <= o_next_row;
            end else begin
                r_count <= w_count_inc[7:0];
            end
        end
    end

endmodule

FILE: rtl/core/led_matrix_frame_loader_scanner.sv
// Top level of the LED matrix frame loader and row scanner.
//
// Items arrive on the s_axis channel: tuser is the operation (0 for a received
// serial byte, 1 for a timer tick) and tdata carries the received byte.
// Results leave on the m_axis channel: tdata holds the active-low row select in
// bits 7:0 and the row pixel byte in bits 15:8, and tuser is the frame done flag.
// A byte that completes a frame load gives one result with frame done set, and
// a tick that ends a row period gives one result for the next row.
// The configuration channel writes the header value (index 0) and the ticks per
// row (index 1) and is always ready; the user must write it only while the block
// is idle; the block does not enforce this. An item is registered on transfer
// and processed once the output register can accept. One item can be taken
// every cycle while the receiver keeps up; the single output register sets that
// figure. When the receiver stalls, the output register holds its result and the
// input register fills, after which s_axis_tready drops until the result leaves.
// Reset clears the parser, the scan row and the tick counter and loads the frame
// buffer with its start pattern.
module led_matrix_frame_loader_scanner
    import lmfls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // row_select, row_data
    output logic        m_axis_tuser,   // frame_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic             r_in_valid;
    logic             r_in_op;
    logic [7:0]       r_in_byte;
    logic [7:0]       r_header_value;
    logic [7:0]       r_scan_ticks;
    logic             r_out_valid;
    logic [7:0]       r_out_sel;
    logic [7:0]       r_out_data;
    logic             r_out_done;
    logic             w_step;
    logic             w_has_result;
    logic [ROW_W-1:0] w_scan_row;
    logic [ROW_W-1:0] w_next_row;
    logic [ROW_W-1:0] w_rd_row;
    logic             w_advance;
    t_parse_res       w_parse;

    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;
    assign o_cfg_ready   = 1'b1;
    assign w_rd_row      = (r_in_op == OP_TICK) ? w_next_row : w_scan_row;
    assign w_has_result  = (r_in_op == OP_TICK) ? w_advance : w_parse.done;

    lmfls_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step && (r_in_op == OP_BYTE)),
        .i_byte         (r_in_byte),
        .i_header_value (r_header_value),
        .i_rd_row       (w_rd_row),
        .o_res          (w_parse)
    );

    lmfls_scanner u_scanner (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_step && (r_in_op == OP_TICK)),
        .i_scan_ticks (r_scan_ticks),
        .o_row        (w_scan_row),
        .o_next_row   (w_next_row),
        .o_advance    (w_advance)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_value <= RESET_HEADER_VALUE;
            r_scan_ticks   <= RESET_SCAN_TICKS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_HEADER_VALUE: r_header_value <= i_cfg_data;
                CFG_SCAN_TICKS:   r_scan_ticks   <= i_cfg_data;
                default:          r_scan_ticks   <= r_scan_ticks;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_has_result) begin
            r_out_sel  <= row_select(w_rd_row);
            r_out_data <= w_parse.row_data;
            r_out_done <= (r_in_op == OP_BYTE);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_data, r_out_sel};
    assign m_axis_tuser  = r_out_done;

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_has_result) |=> m_axis_tvalid)
        else $error("processed item with a result did not load the output register");

    a_row_moves_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_scan_row != $past(w_scan_row)) |-> $past(w_step && (r_in_op == OP_TICK)))
        else $error("scan row changed without a processed tick");

    a_one_row_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($countones(~m_axis_tdata[7:0]) == 1))
        else $error("row select does not drive exactly one row line");

    a_tick_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_has_result && (r_in_op == OP_TICK)) |=> !m_axis_tuser)
        else $error("tick result flagged as frame done");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the LED matrix frame loader and row scanner.
`timescale 1ns / 1ps

module testbench;
    import lmfls_pkg::*;

    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 256;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [7:0] POWER_ON_ROWS [8] = '{
        8'h00, 8'h00, 8'h40, 8'h40, 8'h7E, 8'h40, 8'h40, 8'h00
    };

    typedef enum logic [1:0] {HUNTING, AWAIT_LENGTH, LOADING} t_parse;

    typedef struct packed {
        logic [7:0] sel;
        logic [7:0] data;
        logic       done;
    } t_row_out;

    typedef struct packed {
        logic     op;
        logic [7:0] rx;
        logic     typed;
        t_row_out want;
    } t_stim_row;

    localparam t_stim_row OPENING [17] = '{
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'hFF, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b0, '0},
        '{OP_TICK, 8'h00, 1'b1, '{8'hBF, 8'h00, 1'b0}},
        '{OP_BYTE, 8'h00, 1'b0, '0},
        '{OP_BYTE, 8'h00, 1'b0, '0},
        '{OP_BYTE, 8'hFF, 1'b0, '0},
        '{OP_BYTE, 8'h00, 1'b0, '0},
        '{OP_BYTE, 8'h00, 1'b0, '0},
        '{OP_BYTE, 8'h00, 1'b0, '0},
        '{OP_BYTE, 8'h00, 1'b0, '0},
        '{OP_BYTE, 8'h00, 1'b0, '0},
        '{OP_BYTE, 8'h00, 1'b0, '0},
        '{OP_BYTE, 8'h00, 1'b0, '0},
        '{OP_BYTE, 8'h00, 1'b1, '{8'hBF, 8'h00, 1'b1}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // rx_byte
    logic        s_axis_tuser = 1'b0;    // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // row_select, row_data
    logic        m_axis_tuser;           // frame_done
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_HEADER_VALUE;
    logic [7:0]  i_cfg_data = 8'h00;

    logic [7:0] hdr_val;
    logic [7:0] ticks_per_row;
    t_parse     phase;
    int         hdr_seen;
    int         left;
    int         next_wr;
    logic [7:0] frame_buf [ROWS];
    int         lit_row;
    int         tick_cnt;

    t_row_out pending_rows [$];
    int       fail_cnt = 0;
    int       items_sent = 0;
    int       quiet_cycles = 0;
    int       hold_asked = 0;
    int       hold_served = 0;
    bit       calm = 1'b0;

    led_matrix_frame_loader_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    task automatic reset_scanner_state();
        hdr_val = RESET_HEADER_VALUE;
        ticks_per_row = RESET_SCAN_TICKS;
        phase = HUNTING;
        hdr_seen = 0;
        left = 0;
        next_wr = 0;
        for (int i = 0; i < ROWS; i++) begin
            frame_buf[i] = (i < 8) ? POWER_ON_ROWS[i] : 8'h00;
        end
        lit_row = 0;
        tick_cnt = 0;
    endtask

    function automatic t_row_out lit_row_out(input logic done);
        t_row_out r;
        logic [7:0] line_on;
        line_on = 8'h80 >> lit_row;
        r.sel = (lit_row < 8) ? ~line_on : 8'hFF;
        r.data = frame_buf[lit_row];
        r.done = done;
        return r;
    endfunction

    task automatic step_frame_scanner(input logic op, input logic [7:0] b,
                                      output bit has, output t_row_out r);
        int lim;
        has = 1'b0;
        r = '0;
        if (op == OP_TICK) begin
            lim = (ticks_per_row == 8'd0) ? 1 : int'(ticks_per_row);
            tick_cnt++;
            if (tick_cnt >= lim) begin
                tick_cnt = 0;
                lit_row = (lit_row + 1) % ROWS;
                has = 1'b1;
                r = lit_row_out(1'b0);
            end
        end else begin
            case (phase)
                HUNTING: begin
                    if (b == hdr_val) begin
                        hdr_seen++;
                        if (hdr_seen >= HEADER_LEN) begin
                            hdr_seen = 0;
                            phase = AWAIT_LENGTH;
                        end
                    end else begin
                        hdr_seen = 0;
                    end
                end
                AWAIT_LENGTH: begin
                    left = b;
                    next_wr = 0;
                    if (left == 0) begin
                        phase = HUNTING;
                        has = 1'b1;
                        r = lit_row_out(1'b1);
                    end else begin
                        phase = LOADING;
                    end
                end
                default: begin
                    if (next_wr < ROWS) begin
                        frame_buf[next_wr] = b;
                        next_wr++;
                    end
                    if (left > 0) left--;
                    if (left == 0) begin
                        phase = HUNTING;
                        hdr_seen = 0;
                        has = 1'b1;
                        r = lit_row_out(1'b1);
                    end
                end
            endcase
        end
    endtask

    task automatic send_item(input logic op, input logic [7:0] b, input logic typed,
                             input t_row_out typed_row);
        int gap;
        bit has;
        t_row_out got;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < 38) gap++;
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        step_frame_scanner(op, b, has, got);
        if (typed) pending_rows.push_back(typed_row);
        else if (has) pending_rows.push_back(got);
    endtask

    task automatic send_serial(input logic [7:0] b);
        if ($urandom_range(0, 99) < 20) begin
            send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
        end
        send_item(OP_BYTE, b, 1'b0, '0);
    endtask

    task automatic send_frame();
        int pick;
        int len;
        repeat (HEADER_LEN) send_serial(hdr_val);
        pick = $urandom_range(0, 99);
        if (pick < 4) len = $urandom_range(0, 255);
        else if (pick < 14) len = 0;
        else len = $urandom_range(1, ROWS + 4);
        send_serial(8'(len));
        repeat (len) send_serial(8'($urandom_range(0, 255)));
    endtask

    task automatic send_broken_header();
        logic [7:0] b;
        repeat ($urandom_range(0, HEADER_LEN - 1)) send_serial(hdr_val);
        b = 8'($urandom_range(0, 255));
        if (b == hdr_val) b = ~b;
        send_serial(b);
        repeat ($urandom_range(0, 3)) send_serial(8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(input int n_items);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_frame();
            end else if (pick < 85) begin
                send_broken_header();
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
                end
            end
        end
    endtask

    task automatic write_settings(input logic [7:0] hv, input logic [7:0] st);
        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_HEADER_VALUE;
        i_cfg_data <= hv;
        do @(posedge i_clk); while (!o_cfg_ready);
        hdr_val = hv;
        i_cfg_index <= CFG_SCAN_TICKS;
        i_cfg_data <= st;
        do @(posedge i_clk); while (!o_cfg_ready);
        ticks_per_row = st;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 38);
        end
    end

    always @(posedge i_clk) begin
        t_row_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rows.size() == 0) begin
                $error("unexpected result: row_select %h row_data %h frame_done %b",
                       m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser);
                fail_cnt++;
            end else begin
                want = pending_rows.pop_front();
                if (m_axis_tdata[7:0] !== want.sel) begin
                    $error("row_select: expected %h, got %h", want.sel, m_axis_tdata[7:0]);
                    fail_cnt++;
                end
                if (m_axis_tdata[15:8] !== want.data) begin
                    $error("row_data: expected %h, got %h", want.data, m_axis_tdata[15:8]);
                    fail_cnt++;
                end
                if (m_axis_tuser !== want.done) begin
                    $error("frame_done: expected %b, got %b", want.done, m_axis_tuser);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_scanner_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < $size(OPENING); k++) begin
            send_item(OPENING[k].op, OPENING[k].rx, OPENING[k].typed, OPENING[k].want);
        end

        write_settings(8'hFF, 8'd1);
        run_phase(PHASE_ITEMS);
        write_settings(8'h00, 8'd255);
        run_phase(PHASE_ITEMS);

        calm = 1'b1;
        write_settings(8'($urandom_range(0, 255)), 8'd0);
        run_phase(20);
        hold_asked++;
        run_phase(PHASE_ITEMS - 20);
        calm = 1'b0;

        write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(2, 9)));
        run_phase(PHASE_ITEMS);
        write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(1, 4)));
        run_phase(PHASE_ITEMS);

        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/lmfls_pkg.sv
rtl/core/lmfls_parser.sv
rtl/core/lmfls_scanner.sv
rtl/core/led_matrix_frame_loader_scanner.sv
tb/testbench.sv
